>>> sv/svm_pkg.sv
// svm_pkg: shared types and constants of the sample voice mixer.
// No dependencies; imported by every module of the block.
`default_nettype none
package svm_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_FRAME = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VREAD,
        S_CHECK,
        S_FETCH,
        S_MIX,
        S_WBACK,
        S_DONE
    } t_state;

    // Per-voice settings as held in the voice memory.
    typedef struct packed {
        logic [12:0]        base;
        logic [13:0]        frames;
        logic               stereo;
        logic               wide;
        logic [6:0]         volume;
        logic [19:0]        step_raw;
        logic signed [9:0]  balance;
        logic [7:0]         loop_times;
    } t_settings;

    // Sideband that follows one channel through the arithmetic pipeline.
    typedef struct packed {
        logic valid;
        logic right;
    } t_mix_tag;

    localparam int C_SET_W     = $bits(t_settings);
    localparam int C_GAIN_W    = 22;
    localparam int C_MAG_SHIFT = 27;
    localparam int C_RECIP_W   = 26;
    localparam int C_RECIP_SH  = 35;
    // ceil(2^35 / 625): exact quotient for dividends below 2^26.
    localparam logic [C_RECIP_W-1:0] C_RECIP = 26'd54975582;
    localparam logic [6:0] C_VOL_MAX = 7'd100;
    localparam logic signed [9:0] C_BAL_MAX = 10'sd256;
    localparam logic signed [9:0] C_BAL_MIN = -10'sd256;
    localparam int C_BYTES_PER_VOICE = 8;

endpackage
`default_nettype wire

>>> sv/sample_voice_mixer.sv
// sample_voice_mixer: top level, sequencer over voice memory and sample store.
// Depends on svm_pkg, svm_ram, svm_dsp.
//
//  channel   | dir | transfer when            | payload
//  s_axis    | in  | tvalid & tready          | tuser action, tdata item fields
//  m_axis    | out | tvalid & tready          | tdata left, right, active mask
//  cfg       | in  | i_cfg_wr_en              | master volume
//
// Write, start and stop items are handled in the idle state. A frame item
// visits every voice slot; each voice that plays fetches its sample bytes
// through the store port and runs the five-stage arithmetic pipeline once
// per channel; a voice that ends with no loop left is retired unmixed.
// Reset is synchronous; all voices inactive, master volume 100.
// A finished frame waits in the output register; the next item is taken
// meanwhile, and only a second frame stalls until the first is moved.
`default_nettype none
module sample_voice_mixer
    import svm_pkg::*;
#(
    parameter int VOICES      = 8,
    parameter int STORE_BYTES = 8192,   // power of two
    parameter int FRAC_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // low to high: voice, address, byte_value, frame_count, stereo,
    // sixteen_bit, volume, rate_step, balance, loop_times, zero fill
    input  wire logic [87:0] s_axis_tdata,
    // action
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // low to high: left, right, active_mask
    output logic [39:0]      m_axis_tdata
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int KW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int POS_W = 32 + FRAC_BITS;
    localparam int VW    = C_SET_W + 8 + POS_W;
    localparam int SUM_W = 18 + KW;

    // ---- input fields
    t_action            in_action;
    logic [2:0]         in_voice;
    logic [12:0]        in_address;
    logic [7:0]         in_byte;
    logic [13:0]        in_frames;
    logic               in_stereo, in_wide;
    logic [6:0]         in_volume;
    logic [19:0]        in_step;
    logic signed [9:0]  in_balance;
    logic [7:0]         in_loops;

    assign in_action  = t_action'(s_axis_tuser);
    assign in_voice   = s_axis_tdata[2:0];
    assign in_address = s_axis_tdata[15:3];
    assign in_byte    = s_axis_tdata[23:16];
    assign in_frames  = s_axis_tdata[37:24];
    assign in_stereo  = s_axis_tdata[38];
    assign in_wide    = s_axis_tdata[39];
    assign in_volume  = s_axis_tdata[46:40];
    assign in_step    = s_axis_tdata[66:47];
    assign in_balance = s_axis_tdata[76:67];
    assign in_loops   = s_axis_tdata[84:77];

    // ---- registers
    t_state              r_state, n_state;
    logic [KW-1:0]       r_k, n_k;
    logic [3:0]          r_cnt, n_cnt;
    logic [VOICES-1:0]   r_active, n_active;
    logic [6:0]          r_master, n_master;
    logic signed [SUM_W-1:0] r_sum_l, n_sum_l, r_sum_r, n_sum_r;
    logic [7:0]          r_mask, n_mask;
    t_settings           r_set, n_set;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [7:0]          r_loops, n_loops;
    logic [13:0]         r_mv, n_mv;
    logic [C_GAIN_W-1:0] r_gl, n_gl, r_gr, n_gr;
    logic                r_out_valid, n_out_valid;
    logic [39:0]         r_out_data, n_out_data;
    logic [7:0]          r_byte [C_BYTES_PER_VOICE];

    // ---- memories and pipeline
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_q;
    logic          vr_we;
    logic [KW-1:0] vr_waddr;
    logic [VW-1:0] vr_wdata, vr_q;
    t_mix_tag      mix_in, mix_out;
    logic signed [15:0] mix_a, mix_b, mix_val;

    svm_ram #(.DEPTH(STORE_BYTES), .WIDTH(8)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (in_byte),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    svm_ram #(.DEPTH(VOICES), .WIDTH(VW)) u_voices (
        .i_clk   (i_clk),
        .i_we    (vr_we),
        .i_waddr (vr_waddr),
        .i_wdata (vr_wdata),
        .i_raddr (r_k),
        .o_rdata (vr_q)
    );

    svm_dsp #(.FRAC_BITS(FRAC_BITS)) u_dsp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (mix_in),
        .i_a     (mix_a),
        .i_b     (mix_b),
        .i_frac  (r_pos[FRAC_BITS-1:0]),
        .i_gain  (mix_in.right ? r_gr : r_gl),
        .o_tag   (mix_out),
        .o_value (mix_val)
    );

    // ---- helpers
    function automatic logic signed [15:0] sample_of(
        input logic [7:0] lo, input logic [7:0] hi, input logic wide, input logic ok);
        logic [15:0] s;
        s = wide ? {hi, lo} : {lo ^ 8'h80, 8'h00};
        return ok ? $signed(s) : 16'sd0;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(32767)) begin
            return 16'sh7FFF;
        end else if (v < -SUM_W'(32768)) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    // ---- datapath decode
    t_settings        rd_set, start_set;
    logic [7:0]       rd_loops;
    logic [POS_W-1:0] rd_pos, step_q;
    logic [31:0]      pos_int;
    logic             ended, loops_on, last_k;
    logic [8:0]       loops_inc;
    logic [13:0]      frm_idx;
    logic [2:0]       sel;
    logic [31:0]      fetch_addr;
    logic             ok0, ok1;
    logic signed [15:0] l0, r0, l1, r1;
    logic signed [9:0]  bal_l, bal_r;
    logic [6:0]       mc;

    always_comb begin
        rd_set    = t_settings'(vr_q[VW-1 -: C_SET_W]);
        rd_loops  = vr_q[POS_W +: 8];
        rd_pos    = vr_q[POS_W-1:0];
        pos_int   = rd_pos[POS_W-1:FRAC_BITS];
        ended     = pos_int >= 32'(rd_set.frames);
        loops_inc = {1'b0, rd_loops} + 9'd1;
        loops_on  = (rd_set.frames != '0) && ((rd_set.loop_times == 8'd1) ||
                    ((rd_set.loop_times > 8'd1) && (loops_inc < {1'b0, rd_set.loop_times})));
        step_q    = POS_W'({r_set.step_raw, 24'b0} >> (40 - FRAC_BITS));
        last_k    = (r_k == KW'(VOICES - 1));

        start_set.base       = in_address;
        start_set.frames     = in_frames;
        start_set.stereo     = in_stereo;
        start_set.wide       = in_wide;
        start_set.volume     = (in_volume > C_VOL_MAX) ? C_VOL_MAX : in_volume;
        start_set.step_raw   = in_step;
        start_set.balance    = (in_balance > C_BAL_MAX) ? C_BAL_MAX :
                               (in_balance < C_BAL_MIN) ? C_BAL_MIN : in_balance;
        start_set.loop_times = in_loops;

        // byte fetch order: {frame, channel, byte}
        sel     = r_cnt[2:0];
        frm_idx = r_pos[FRAC_BITS +: 14] + {13'b0, sel[2]};
        fetch_addr = 32'(r_set.base)
                   + (32'(frm_idx) << ({1'b0, r_set.wide} + {1'b0, r_set.stereo}))
                   + (sel[1] ? (r_set.wide ? 32'd2 : 32'd1) : 32'd0)
                   + ((r_set.wide && sel[0]) ? 32'd1 : 32'd0);

        // frames at or past the end read as zero
        ok0 = r_pos[POS_W-1:FRAC_BITS] < 32'(r_set.frames);
        ok1 = (33'(r_pos[POS_W-1:FRAC_BITS]) + 33'd1) < 33'(r_set.frames);
        l0  = sample_of(r_byte[0], r_byte[1], r_set.wide, ok0);
        r0  = r_set.stereo ? sample_of(r_byte[2], r_byte[3], r_set.wide, ok0) : l0;
        l1  = sample_of(r_byte[4], r_byte[5], r_set.wide, ok1);
        r1  = r_set.stereo ? sample_of(r_byte[6], r_byte[7], r_set.wide, ok1) : l1;

        bal_l = C_BAL_MAX - ((r_set.balance > 10'sd0) ? r_set.balance : 10'sd0);
        bal_r = C_BAL_MAX + ((r_set.balance < 10'sd0) ? r_set.balance : 10'sd0);
        mc    = (r_master > C_VOL_MAX) ? C_VOL_MAX : r_master;
    end

    // ---- sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_active    = r_active;
        n_master    = i_cfg_wr_en ? i_cfg_wr_data : r_master;
        n_sum_l     = r_sum_l;
        n_sum_r     = r_sum_r;
        n_mask      = r_mask;
        n_set       = r_set;
        n_pos       = r_pos;
        n_loops     = r_loops;
        n_mv        = r_mv;
        n_gl        = C_GAIN_W'(r_mv * bal_l[8:0]);
        n_gr        = C_GAIN_W'(r_mv * bal_r[8:0]);
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        s_axis_tready = (r_state == S_IDLE);
        st_we    = 1'b0;
        st_waddr = AW'(32'(in_address));
        st_raddr = fetch_addr[AW-1:0];
        vr_we    = 1'b0;
        vr_waddr = r_k;
        vr_wdata = {r_set, r_loops, r_pos + step_q};
        mix_in   = '0;
        mix_a    = l0;
        mix_b    = l1;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_action)
                        ACT_WRITE: st_we = 1'b1;
                        ACT_START: begin
                            if (32'(in_voice) < VOICES) begin
                                vr_we    = 1'b1;
                                vr_waddr = KW'(in_voice);
                                vr_wdata = {start_set, 8'd0, POS_W'(0)};
                                n_active[KW'(in_voice)] = 1'b1;
                            end
                        end
                        ACT_STOP: begin
                            if (32'(in_voice) < VOICES) begin
                                n_active[KW'(in_voice)] = 1'b0;
                            end
                        end
                        ACT_FRAME: begin
                            n_k     = '0;
                            n_sum_l = '0;
                            n_sum_r = '0;
                            n_mask  = '0;
                            n_state = S_VREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_VREAD: begin
                // voice memory read of slot r_k is in flight
                if (r_active[r_k]) begin
                    n_state = S_CHECK;
                end else if (last_k) begin
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_CHECK: begin
                n_set   = rd_set;
                n_mv    = 14'(mc) * 14'(rd_set.volume);
                n_cnt   = '0;
                n_pos   = rd_pos;
                n_loops = rd_loops;
                if (ended && !loops_on) begin
                    n_active[r_k] = 1'b0;
                    if (last_k) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = S_VREAD;
                    end
                end else begin
                    if (ended) begin
                        n_loops = loops_inc[7:0];
                        n_pos   = rd_pos - (POS_W'(rd_set.frames) << FRAC_BITS);
                    end
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(C_BYTES_PER_VOICE)) begin
                    n_cnt   = '0;
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd0) begin
                    mix_in.valid = 1'b1;
                end else if (r_cnt == 4'd1) begin
                    mix_in.valid = 1'b1;
                    mix_in.right = 1'b1;
                    mix_a        = r0;
                    mix_b        = r1;
                end
                if (mix_out.valid) begin
                    if (mix_out.right) begin
                        n_sum_r = r_sum_r + SUM_W'(mix_val);
                        n_state = S_WBACK;
                    end else begin
                        n_sum_l = r_sum_l + SUM_W'(mix_val);
                    end
                end
            end
            S_WBACK: begin
                vr_we  = 1'b1;
                n_mask = r_mask | (8'd1 << r_k);
                if (last_k) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = S_VREAD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_mask, clamp16(r_sum_r), clamp16(r_sum_l)};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_master    <= C_VOL_MAX;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_master    <= n_master;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
        end
        r_sum_l    <= n_sum_l;
        r_sum_r    <= n_sum_r;
        r_mask     <= n_mask;
        r_set      <= n_set;
        r_pos      <= n_pos;
        r_loops    <= n_loops;
        r_mv       <= n_mv;
        r_gl       <= n_gl;
        r_gr       <= n_gr;
        r_out_data <= n_out_data;
        // store data arrives in the cycle after its address
        if (r_state == S_FETCH && r_cnt != 4'd0) begin
            r_byte[3'(r_cnt - 4'd1)] <= st_q;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

>>> sv/svm_ram.sv
// svm_ram: simple dual-port synchronous RAM, one write and one registered read.
// Uses svm_pkg only by convention; holds sample bytes or voice state.
`default_nettype none
module svm_ram
    import svm_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/svm_dsp.sv
// svm_dsp: five-stage pipeline for one channel: interpolate, apply gain,
// scale and truncate toward zero. Depends on svm_pkg.
`default_nettype none
module svm_dsp
    import svm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_mix_tag              i_tag,
    input  wire logic signed [15:0]    i_a,
    input  wire logic signed [15:0]    i_b,
    input  wire logic [FRAC_BITS-1:0]  i_frac,
    input  wire logic [C_GAIN_W-1:0]   i_gain,
    output t_mix_tag                   o_tag,
    output logic signed [15:0]         o_value
);

    localparam int P1W = 18 + FRAC_BITS;
    localparam int P2W = 16 + C_GAIN_W + 1;
    localparam int NW  = P2W + 15;

    t_mix_tag r_tag1, r_tag2, r_tag3, r_tag4;
    logic signed [P1W-1:0]    r_p1;
    logic signed [15:0]       r_a1;
    logic [C_GAIN_W-1:0]      r_g1;
    logic signed [P2W-1:0]    r_p2;
    logic [C_RECIP_W-1:0]     r_u3;
    logic                     r_neg3, r_neg4;
    logic [15:0]              r_q4;

    logic signed [16:0]       diff;
    logic signed [P1W-1:0]    p1;
    logic signed [P1W-1:0]    lerp_sum;
    logic signed [15:0]       x;
    logic signed [P2W-1:0]    p2;
    logic signed [NW-1:0]     n_scaled;
    logic [NW-1:0]            mag;
    logic [2*C_RECIP_W-1:0]   q;

    always_comb begin
        diff     = {i_b[15], i_b} - {i_a[15], i_a};
        p1       = P1W'(diff * $signed({1'b0, i_frac}));
        // a + floor((b - a) * f / 2^F) is the floor of the weighted sum
        lerp_sum = P1W'(r_a1) + (r_p1 >>> FRAC_BITS);
        x        = lerp_sum[15:0];
        p2       = P2W'(x * $signed({1'b0, r_g1}));
        n_scaled = (NW'(r_p2) <<< 15) - NW'(r_p2);
        mag      = n_scaled[NW-1] ? NW'(-n_scaled) : NW'(n_scaled);
        q        = r_u3 * C_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            o_tag  <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            o_tag  <= r_tag4;
        end
        r_p1    <= p1;
        r_a1    <= i_a;
        r_g1    <= i_gain;
        r_p2    <= p2;
        r_u3    <= mag[C_MAG_SHIFT +: C_RECIP_W];
        r_neg3  <= n_scaled[NW-1];
        r_q4    <= q[C_RECIP_SH +: 16];
        r_neg4  <= r_neg3;
        o_value <= r_neg4 ? -$signed(r_q4) : $signed(r_q4);
    end

endmodule
`default_nettype wire

>>> sv/svm_checker.sv
// svm_checker: port-level assertions for sample_voice_mixer, bound to the top.
// Depends on svm_pkg.
`default_nettype none
module svm_checker
    import svm_pkg::*;
#(
    parameter int VOICES = 8
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_wr_en,
    input wire logic [6:0]  i_cfg_wr_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [87:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    logic frame_in, other_in;
    assign frame_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_FRAME);
    assign other_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_FRAME);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_in |=> !s_axis_tready && !(m_axis_tvalid && !$past(m_axis_tvalid)))
        else $error("frame transfer did not occupy the mixer");

    a_other_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        other_in |=> s_axis_tready)
        else $error("non-frame transfer stalled input");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((9'(m_axis_tdata[39:32]) >> VOICES) == 9'd0))
        else $error("active mask names a missing voice");

endmodule

bind sample_voice_mixer svm_checker #(.VOICES(VOICES)) u_svm_checker (.*);
`default_nettype wire
